>>> rtl/core/bmp24_pkg.sv
// bmp24_pkg: constants, status codes and the result word type
// for the 24-bit BMP stream decoder. No dependencies.
package bmp24_pkg;

  localparam logic [31:0] MAX_DIMENSION = 32'd4096;

  localparam logic [7:0]  SIG_FIRST     = 8'h42;  // 'B'
  localparam logic [7:0]  SIG_SECOND    = 8'h4D;  // 'M'
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [15:0] PIXEL_BITS    = 16'd24;
  localparam logic [31:0] HDR_TOTAL     = 32'd54;

  // header byte positions
  localparam logic [5:0] IDX_SIG0     = 6'd0;
  localparam logic [5:0] IDX_SIG1     = 6'd1;
  localparam logic [5:0] IDX_OFS_LO   = 6'd10;
  localparam logic [5:0] IDX_OFS_HI   = 6'd13;
  localparam logic [5:0] IDX_INFO_LO  = 6'd14;
  localparam logic [5:0] IDX_INFO_HI  = 6'd17;
  localparam logic [5:0] IDX_WID_LO   = 6'd18;
  localparam logic [5:0] IDX_WID_HI   = 6'd21;
  localparam logic [5:0] IDX_HGT_LO   = 6'd22;
  localparam logic [5:0] IDX_HGT_HI   = 6'd25;
  localparam logic [5:0] IDX_BITS_LO  = 6'd28;
  localparam logic [5:0] IDX_BITS_HI  = 6'd29;
  localparam logic [5:0] IDX_HDR_LAST = 6'd53;

  typedef enum logic [2:0] {
    ST_PIXEL         = 3'd0,
    ST_HEADER_OK     = 3'd1,
    ST_BAD_SIGNATURE = 3'd2,
    ST_BAD_INFO_SIZE = 3'd3,
    ST_BAD_BITS      = 3'd4,
    ST_BAD_OFFSET    = 3'd5,
    ST_TOO_LARGE     = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    status_t     status;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_in_image;
  } result_t;

endpackage

>>> rtl/core/bmp24_stream_decoder.sv
// bmp24_stream_decoder: byte-serial 24-bit BMP parser, header checks and BGR->RGB pixels.
// Depends on bmp24_pkg.
// A byte's result word, if any, is registered and shown on out_valid in the next cycle.
// Throughput: one byte per cycle; the only stall is a full, stalled output register.
// Reset (rst_n low, synchronous): parser idle until a byte with start_of_file,
// output register empty.
module bmp24_stream_decoder
  import bmp24_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [2:0]  out_status,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic        out_last_in_image
);

  typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_PIXEL, PH_PAD, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [5:0]  hdr_cnt_r, hdr_cnt_nxt, idx;
  logic [7:0]  sig_first_r, sig_first_nxt;
  logic [31:0] data_offset_r, data_offset_nxt;
  logic [31:0] info_size_r, info_size_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] bit_depth_r, bit_depth_nxt;
  logic [1:0]  byte_in_pixel_r, byte_in_pixel_nxt;
  logic [7:0]  held_blue_r, held_blue_nxt;
  logic [7:0]  held_green_r, held_green_nxt;
  logic [12:0] column_r, column_nxt, column_inc;
  logic [12:0] row_r, row_nxt, row_inc;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  lane;
  logic        accept, emit, load, too_large, empty;
  result_t     res_r, res_nxt;
  logic        out_valid_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && emit;

  assign ph   = in_start_of_file ? PH_HEADER : phase_r;
  assign idx  = in_start_of_file ? IDX_SIG0 : hdr_cnt_r;
  assign lane = idx[1:0] - 2'd2;  // byte lane of the offset/info/width/height fields

  assign column_inc = column_r + 13'd1;
  assign row_inc    = row_r + 13'd1;

  assign too_large = width_r[31] || height_r[31] ||
                     (width_r > MAX_DIMENSION) || (height_r > MAX_DIMENSION);
  assign empty     = (width_r == 32'd0) || (height_r == 32'd0);

  always_comb begin
    phase_nxt         = phase_r;
    hdr_cnt_nxt       = hdr_cnt_r;
    sig_first_nxt     = sig_first_r;
    data_offset_nxt   = data_offset_r;
    info_size_nxt     = info_size_r;
    width_nxt         = width_r;
    height_nxt        = height_r;
    bit_depth_nxt     = bit_depth_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    held_blue_nxt     = held_blue_r;
    held_green_nxt    = held_green_r;
    column_nxt        = column_r;
    row_nxt           = row_r;
    pad_nxt           = pad_r;
    emit              = 1'b0;
    res_nxt           = '0;
    res_nxt.status    = ST_PIXEL;

    if (accept) begin
      if (in_start_of_file) begin
        byte_in_pixel_nxt = 2'd0;
        column_nxt        = '0;
        row_nxt           = '0;
        pad_nxt           = 2'd0;
      end
      case (ph)
        PH_HEADER: begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = idx + 6'd1;
          if (idx == IDX_SIG0) sig_first_nxt = in_file_byte;
          if (idx inside {[IDX_OFS_LO:IDX_OFS_HI]})
            data_offset_nxt[{lane, 3'b000} +: 8] = in_file_byte;
          if (idx inside {[IDX_INFO_LO:IDX_INFO_HI]})
            info_size_nxt[{lane, 3'b000} +: 8] = in_file_byte;
          if (idx inside {[IDX_WID_LO:IDX_WID_HI]})
            width_nxt[{lane, 3'b000} +: 8] = in_file_byte;
          if (idx inside {[IDX_HGT_LO:IDX_HGT_HI]})
            height_nxt[{lane, 3'b000} +: 8] = in_file_byte;
          if (idx inside {[IDX_BITS_LO:IDX_BITS_HI]})
            bit_depth_nxt[{idx[0], 3'b000} +: 8] = in_file_byte;

          if (idx == IDX_SIG1 && (sig_first_r != SIG_FIRST || in_file_byte != SIG_SECOND)) begin
            emit           = 1'b1;
            res_nxt.status = ST_BAD_SIGNATURE;
            phase_nxt      = PH_DONE;
          end else if (idx == IDX_INFO_HI && info_size_nxt != INFO_HDR_SIZE) begin
            emit           = 1'b1;
            res_nxt.status = ST_BAD_INFO_SIZE;
            phase_nxt      = PH_DONE;
          end else if (idx == IDX_HDR_LAST) begin
            emit      = 1'b1;
            phase_nxt = PH_DONE;
            if (bit_depth_r != PIXEL_BITS) begin
              res_nxt.status = ST_BAD_BITS;
            end else if (data_offset_r != HDR_TOTAL) begin
              res_nxt.status = ST_BAD_OFFSET;
            end else if (too_large) begin
              res_nxt.status = ST_TOO_LARGE;
            end else begin
              res_nxt.status        = ST_HEADER_OK;
              res_nxt.image_width   = width_r[12:0];
              res_nxt.image_height  = height_r[12:0];
              res_nxt.last_in_image = empty;
              phase_nxt             = empty ? PH_DONE : PH_PIXEL;
              byte_in_pixel_nxt     = 2'd0;
              column_nxt            = '0;
              row_nxt               = '0;
              pad_nxt               = 2'd0;
            end
          end
        end
        PH_PIXEL: begin
          case (byte_in_pixel_r)
            2'd0: begin
              held_blue_nxt     = in_file_byte;
              byte_in_pixel_nxt = 2'd1;
            end
            2'd1: begin
              held_green_nxt    = in_file_byte;
              byte_in_pixel_nxt = 2'd2;
            end
            default: begin
              byte_in_pixel_nxt = 2'd0;
              emit              = 1'b1;
              res_nxt.red       = in_file_byte;
              res_nxt.green     = held_green_r;
              res_nxt.blue      = held_blue_r;
              column_nxt        = column_inc;
              // width and height are at most MAX_DIMENSION here, so 13 bits hold them
              if (column_inc >= width_r[12:0]) begin
                column_nxt = '0;
                row_nxt    = row_inc;
                if (row_inc >= height_r[12:0]) begin
                  res_nxt.last_in_image = 1'b1;
                  phase_nxt             = PH_DONE;
                end else begin
                  pad_nxt = width_r[1:0];
                  if (width_r[1:0] != 2'd0) phase_nxt = PH_PAD;
                end
              end
            end
          endcase
        end
        PH_PAD: begin
          if (pad_r != 2'd0) pad_nxt = pad_r - 2'd1;
          if (pad_r <= 2'd1) phase_nxt = PH_PIXEL;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      hdr_cnt_r       <= '0;
      byte_in_pixel_r <= 2'd0;
      column_r        <= '0;
      row_r           <= '0;
      pad_r           <= 2'd0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      hdr_cnt_r       <= hdr_cnt_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      column_r        <= column_nxt;
      row_r           <= row_nxt;
      pad_r           <= pad_nxt;
      out_valid_r     <= load || (out_valid_r && out_stall);
      sig_first_r     <= sig_first_nxt;
      data_offset_r   <= data_offset_nxt;
      info_size_r     <= info_size_nxt;
      width_r         <= width_nxt;
      height_r        <= height_nxt;
      bit_depth_r     <= bit_depth_nxt;
      held_blue_r     <= held_blue_nxt;
      held_green_r    <= held_green_nxt;
      if (load) res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = res_r.red;
  assign out_green         = res_r.green;
  assign out_blue          = res_r.blue;
  assign out_status        = res_r.status;
  assign out_image_width   = res_r.image_width;
  assign out_image_height  = res_r.image_height;
  assign out_last_in_image = res_r.last_in_image;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXEL || phase_r == PH_PAD) |-> (column_r < width_r[12:0]))
    else $error("column count reached row width");

  a_row_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXEL || phase_r == PH_PAD) |-> (row_r < height_r[12:0]))
    else $error("row count reached image height");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAD) |-> (pad_r != 2'd0))
    else $error("pad phase with nothing to skip");

  a_pix_byte: assert property (@(posedge clk) disable iff (!rst_n)
    byte_in_pixel_r != 2'd3)
    else $error("byte in pixel out of range");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !load) |=> !out_valid_r)
    else $error("output word taken but still shown");

endmodule
